[src/assert_macros.svh]
// Assertion macros shared by the formatter RTL.
// Each macro takes a label, an antecedent, a consequent and a message; clk_i and rst_ni are implied.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/itoa_fmt_pkg.sv]
// Constants, command codes and the digit-to-character function of the integer formatter.
// Has no dependencies; the formatter top level refers to it by scoped names.
package itoa_fmt_pkg;

  localparam int VALUE_BITS = 64;
  localparam int NARROW_W   = (VALUE_BITS > 32) ? 32 : VALUE_BITS;

  localparam int DEC_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int OCT_DIGITS = (VALUE_BITS + 2) / 3;
  localparam int HEX_DIGITS = (VALUE_BITS + 3) / 4;
  localparam int MAX_DIGITS = (OCT_DIGITS > DEC_DIGITS) ? OCT_DIGITS : DEC_DIGITS;

  // The BCD field is always the widest digit field.
  localparam int EM_W      = DEC_DIGITS * 4;
  localparam int OCT_SHIFT = EM_W - OCT_DIGITS * 3;
  localparam int HEX_SHIFT = EM_W - HEX_DIGITS * 4;

  localparam int DCNT_W = $clog2(MAX_DIGITS + 1);
  localparam int BCNT_W = $clog2(VALUE_BITS + 1);

  localparam logic [VALUE_BITS-1:0] NARROW_MASK = {VALUE_BITS{1'b1}} >> (VALUE_BITS - NARROW_W);

  localparam logic [2:0] CMD_SDEC = 3'd0;
  localparam logic [2:0] CMD_UDEC = 3'd1;
  localparam logic [2:0] CMD_OCT  = 3'd2;
  localparam logic [2:0] CMD_HEXL = 3'd3;
  localparam logic [2:0] CMD_HEXU = 3'd4;

  localparam logic [6:0] CHAR_ZERO  = 7'd48;
  localparam logic [6:0] CHAR_UPPER = 7'd65;
  localparam logic [6:0] CHAR_LOWER = 7'd97;
  localparam logic [6:0] CHAR_MINUS = 7'd45;
  localparam logic [6:0] CHAR_X     = 7'd120;
  localparam logic [6:0] DIGIT_TEN  = 7'd10;

  function automatic logic [6:0] digit_char(input logic [3:0] dig, input logic upper);
    logic [6:0] wide;
    wide = {3'b000, dig};
    if (wide < DIGIT_TEN) begin
      return CHAR_ZERO + wide;
    end
    return (upper ? CHAR_UPPER : CHAR_LOWER) + wide - DIGIT_TEN;
  endfunction

endpackage

[src/integer_to_ascii_formatter.sv]
// Top level of the integer formatter: input decode, serial BCD conversion and character output.
// Depends on itoa_fmt_pkg and on assert_macros.svh.
//
// The block turns one number into ASCII text, one character per output transaction, most
// significant first, with last_char_o set on the final character. It takes one number at a
// time and holds in_stall_o high until the last character has been loaded into the output
// register. Decimal modes run a double-dabble loop over all value bits, one value bit per
// cycle, then drop leading zero digits at one per cycle, leave that step, and send one
// character per cycle while the output does not stall. Leading zeros and digits always add
// up to 20 for a decimal number, which may also get a minus sign. Octal and hex skip the
// conversion loop, drop leading zero digits at one per cycle, leave that step and then send
// their characters, hex with an optional 0x prefix. The next number is taken at the edge
// after the last character is loaded. The output side can stall at any time and simply
// pauses the character sequencer.

`include "assert_macros.svh"

module integer_to_ascii_formatter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  cmd_i,
  input  logic [63:0] value_i,
  input  logic        narrow_i,
  input  logic        hex_prefix_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [6:0]  ascii_char_o,
  output logic        last_char_o
);

  localparam int VB     = itoa_fmt_pkg::VALUE_BITS;
  localparam int EW     = itoa_fmt_pkg::EM_W;
  localparam int DCW    = itoa_fmt_pkg::DCNT_W;
  localparam int BCW    = itoa_fmt_pkg::BCNT_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CONV = 3'd1;
  localparam logic [2:0] S_SKIP = 3'd2;
  localparam logic [2:0] S_SIGN = 3'd3;
  localparam logic [2:0] S_P0   = 3'd4;
  localparam logic [2:0] S_PX   = 3'd5;
  localparam logic [2:0] S_DIG  = 3'd6;

  logic [2:0]     state_q, state_d;
  logic [EW-1:0]  em_q, em_d;
  logic [VB-1:0]  mag_q, mag_d;
  logic [BCW-1:0] bcnt_q, bcnt_d;
  logic [DCW-1:0] dcnt_q, dcnt_d;
  logic           neg_q, neg_d;
  logic           pfx_q, pfx_d;
  logic           oct_q, oct_d;
  logic           upper_q, upper_d;
  logic           out_valid_q, out_valid_d;
  logic [6:0]     out_char_q, out_char_d;
  logic           out_last_q, out_last_d;

  logic           in_accept;
  logic           out_free;
  logic           emit;
  logic [VB-1:0]  val_w;
  logic [VB-1:0]  sx;
  logic [VB-1:0]  sneg;
  logic           ssign;
  logic [EW-1:0]  adj;
  logic [3:0]     top_dig;
  logic [EW-1:0]  em_shift;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign emit       = out_free && (state_q == S_SIGN || state_q == S_P0 ||
                                   state_q == S_PX || state_q == S_DIG);

  assign val_w = value_i[VB-1:0];
  assign sx    = narrow_i ? (val_w & itoa_fmt_pkg::NARROW_MASK) : val_w;
  assign ssign = narrow_i ? val_w[itoa_fmt_pkg::NARROW_W-1] : val_w[VB-1];
  assign sneg  = (~sx + VB'(1)) & (narrow_i ? itoa_fmt_pkg::NARROW_MASK : {VB{1'b1}});

  always_comb begin
    for (int i = 0; i < itoa_fmt_pkg::DEC_DIGITS; i++) begin
      adj[i*4 +: 4] = (em_q[i*4 +: 4] >= 4'd5) ? em_q[i*4 +: 4] + 4'd3 : em_q[i*4 +: 4];
    end
  end

  assign top_dig  = oct_q ? {1'b0, em_q[EW-1 -: 3]} : em_q[EW-1 -: 4];
  assign em_shift = oct_q ? (em_q << 3) : (em_q << 4);

  always_comb begin
    state_d     = state_q;
    em_d        = em_q;
    mag_d       = mag_q;
    bcnt_d      = bcnt_q;
    dcnt_d      = dcnt_q;
    neg_d       = neg_q;
    pfx_d       = pfx_q;
    oct_d       = oct_q;
    upper_d     = upper_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          neg_d   = 1'b0;
          pfx_d   = 1'b0;
          oct_d   = 1'b0;
          upper_d = 1'b0;
          mag_d   = val_w;
          em_d    = '0;
          bcnt_d  = BCW'(VB);
          dcnt_d  = DCW'(itoa_fmt_pkg::DEC_DIGITS);
          state_d = S_CONV;
          unique case (cmd_i) inside
            itoa_fmt_pkg::CMD_SDEC: begin
              neg_d = ssign;
              mag_d = ssign ? sneg : sx;
            end
            itoa_fmt_pkg::CMD_OCT: begin
              oct_d   = 1'b1;
              em_d    = EW'(val_w) << itoa_fmt_pkg::OCT_SHIFT;
              dcnt_d  = DCW'(itoa_fmt_pkg::OCT_DIGITS);
              state_d = S_SKIP;
            end
            itoa_fmt_pkg::CMD_HEXL, itoa_fmt_pkg::CMD_HEXU: begin
              upper_d = (cmd_i == itoa_fmt_pkg::CMD_HEXU);
              pfx_d   = hex_prefix_i;
              em_d    = EW'(val_w) << itoa_fmt_pkg::HEX_SHIFT;
              dcnt_d  = DCW'(itoa_fmt_pkg::HEX_DIGITS);
              state_d = S_SKIP;
            end
            default: begin
            end
          endcase
        end
      end
      S_CONV: begin
        em_d   = {adj[EW-2:0], mag_q[VB-1]};
        mag_d  = mag_q << 1;
        bcnt_d = bcnt_q - BCW'(1);
        if (bcnt_q == BCW'(1)) begin
          state_d = S_SKIP;
        end
      end
      S_SKIP: begin
        if (top_dig == 4'd0 && dcnt_q > DCW'(1)) begin
          em_d   = em_shift;
          dcnt_d = dcnt_q - DCW'(1);
        end else if (neg_q) begin
          state_d = S_SIGN;
        end else if (pfx_q) begin
          state_d = S_P0;
        end else begin
          state_d = S_DIG;
        end
      end
      S_SIGN: begin
        if (emit) begin
          out_char_d = itoa_fmt_pkg::CHAR_MINUS;
          out_last_d = 1'b0;
          state_d    = S_DIG;
        end
      end
      S_P0: begin
        if (emit) begin
          out_char_d = itoa_fmt_pkg::CHAR_ZERO;
          out_last_d = 1'b0;
          state_d    = S_PX;
        end
      end
      S_PX: begin
        if (emit) begin
          out_char_d = itoa_fmt_pkg::CHAR_X;
          out_last_d = 1'b0;
          state_d    = S_DIG;
        end
      end
      S_DIG: begin
        if (emit) begin
          out_char_d = itoa_fmt_pkg::digit_char(top_dig, upper_q);
          out_last_d = (dcnt_q == DCW'(1));
          em_d       = em_shift;
          dcnt_d     = dcnt_q - DCW'(1);
          if (dcnt_q == DCW'(1)) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      bcnt_q      <= '0;
      dcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      bcnt_q      <= bcnt_d;
      dcnt_q      <= dcnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    em_q       <= em_d;
    mag_q      <= mag_d;
    neg_q      <= neg_d;
    pfx_q      <= pfx_d;
    oct_q      <= oct_d;
    upper_q    <= upper_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o  = out_valid_q;
  assign ascii_char_o = out_char_q;
  assign last_char_o  = out_last_q;

  `ASSERT_SAME(a_idle_no_digits, state_q == S_IDLE, dcnt_q == '0, "Idle with digits still pending.")
  `ASSERT_SAME(a_dig_has_count, state_q == S_DIG, dcnt_q != '0, "Digit state with empty digit count.")
  `ASSERT_SAME(a_conv_has_bits, state_q == S_CONV, bcnt_q != '0, "Conversion state with no bits left.")
  `ASSERT_NEXT(a_last_to_idle, emit && out_last_d, state_q == S_IDLE, "Last character did not end the number.")
  `ASSERT_NEXT(a_accept_busy, in_accept, state_q != S_IDLE, "Accepted transaction left the block idle.")

endmodule
